### hdl/pps_pkg.sv
// shared types and codes for the pipelined prime sieve unit
package pps_pkg;

    localparam int CAND_BITS  = 16;
    localparam int PRIME_BITS = 16;

    // input kind codes carried in s_tuser
    localparam logic CMD_CANDIDATE = 1'b0;
    localparam logic CMD_END       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;     // latch candidate, restart cell index
        logic clear;      // empty the chain
        logic rd_en;      // read cell at current index, reset remainder
        logic div_step;   // one remainder step
        logic next_cell;  // advance cell index
        logic emit;       // load output item, store prime if room
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_end;      // input item is end of stream
        logic below_two;   // candidate below two
        logic chain_empty;
        logic div_last;    // current step is the final remainder step
        logic rem_zero;
        logic last_cell;
        logic out_free;    // output slot can take an item this cycle
    } dp_status_t;

endpackage

### hdl/pps_ctrl.sv
// controller state machine for the prime sieve
module pps_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  pps_pkg::dp_status_t    status,
    output pps_pkg::ctrl_cmd_t     cmd
);

    pps_pkg::state_t state_reg;
    pps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    priority if (status.is_end)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (!status.below_two)
                    begin
                        cmd.accept = 1'b1;
                        state_next = status.chain_empty ? pps_pkg::ST_EMIT
                                                        : pps_pkg::ST_READ;
                    end
                end
            end
            pps_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = pps_pkg::ST_DIVIDE;
            end
            pps_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = pps_pkg::ST_CHECK;
                end
            end
            pps_pkg::ST_CHECK:
            begin
                priority if (status.rem_zero)
                begin
                    // divided by a stored prime, item is dropped
                    state_next = pps_pkg::ST_IDLE;
                end
                else if (status.last_cell)
                begin
                    state_next = pps_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = pps_pkg::ST_READ;
                end
            end
            pps_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/pps_datapath.sv
// prime cell store, bit-serial remainder unit and output register
module pps_datapath #(
    parameter int NUM_CELLS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pps_pkg::CAND_BITS-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pps_pkg::PRIME_BITS-1:0]    m_tdata,
    output logic                              m_tuser,
    input  pps_pkg::ctrl_cmd_t                cmd,
    output pps_pkg::dp_status_t               status
);

    localparam int IDX_BITS   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int COUNT_BITS = $clog2(NUM_CELLS + 1);

    logic [VALUE_BITS-1:0] mem [NUM_CELLS];
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] shift_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] step_cnt_reg;
    logic [COUNT_BITS-1:0] idx_reg;
    logic [COUNT_BITS-1:0] used_reg;

    logic                         m_tvalid_reg;
    logic [pps_pkg::PRIME_BITS-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    logic [31:0]           cand_ext;
    logic [VALUE_BITS-1:0] cand_value;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   trial_diff;
    logic [VALUE_BITS-1:0] rem_step;
    logic [31:0]           value_ext;
    logic                  chain_full;

    assign cand_ext   = {16'b0, s_tdata};
    assign cand_value = cand_ext[VALUE_BITS-1:0];
    assign value_ext  = 32'(value_reg);
    assign chain_full = (used_reg == COUNT_BITS'(NUM_CELLS));

    // restoring remainder step, rem stays below the divisor
    assign trial      = {rem_reg, shift_reg[VALUE_BITS-1]};
    assign trial_diff = trial - {1'b0, rd_data_reg};
    assign rem_step   = trial_diff[VALUE_BITS] ? trial[VALUE_BITS-1:0]
                                               : trial_diff[VALUE_BITS-1:0];

    assign status.is_end      = (s_tuser == pps_pkg::CMD_END);
    assign status.below_two   = (cand_value < VALUE_BITS'(2));
    assign status.chain_empty = (used_reg == '0);
    assign status.div_last    = step_cnt_reg[VALUE_BITS-1];
    assign status.rem_zero    = (rem_reg == '0);
    assign status.last_cell   = ((idx_reg + COUNT_BITS'(1)) == used_reg);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit && !chain_full)
        begin
            mem[used_reg[IDX_BITS-1:0]] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg[IDX_BITS-1:0]];
        end
    end

    // payload working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg <= cand_value;
        end
        if (cmd.rd_en)
        begin
            shift_reg    <= value_reg;
            rem_reg      <= '0;
            step_cnt_reg <= VALUE_BITS'(1);
        end
        else if (cmd.div_step)
        begin
            shift_reg    <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg      <= rem_step;
            step_cnt_reg <= {step_cnt_reg[VALUE_BITS-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            m_tdata_reg <= value_ext[pps_pkg::PRIME_BITS-1:0];
            m_tuser_reg <= chain_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_cell)
            begin
                idx_reg <= idx_reg + COUNT_BITS'(1);
            end
            if (cmd.clear)
            begin
                used_reg <= '0;
            end
            else if (cmd.emit && !chain_full)
            begin
                used_reg <= used_reg + COUNT_BITS'(1);
            end
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_BITS'(NUM_CELLS))
        else $error("cell count beyond chain length");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("output item overwritten before taken");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rd_data_reg >= VALUE_BITS'(2)))
        else $error("remainder step against divisor below two");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !chain_full) |=> (used_reg == $past(used_reg) + COUNT_BITS'(1)))
        else $error("stored prime not counted");
`endif

endmodule

### hdl/pipelined_prime_sieve_unit.sv
// Prime sieve: each candidate item is tested against the stored primes in
// storage order by one shared bit-serial remainder unit. For each stored
// cell tried there is a cell read, VALUE_BITS remainder steps and a check;
// a found prime then goes to the output. End of stream and candidates
// below two are handled in the idle state. A found prime waits in an
// output register, so the next item is taken while it is still unread;
// the output of a new prime waits until the previous one has been taken.
// Cells are never cleared; the used count bounds every read.
module pipelined_prime_sieve_unit #(
    parameter int NUM_CELLS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pps_pkg::CAND_BITS-1:0]  s_tdata,   // candidate[15:0]
    input  logic                           s_tuser,   // command[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pps_pkg::PRIME_BITS-1:0] m_tdata,   // prime_value[15:0]
    output logic                           m_tuser    // not_stored[0]
);

    pps_pkg::ctrl_cmd_t  cmd;
    pps_pkg::dp_status_t status;

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_datapath #(
        .NUM_CELLS  (NUM_CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
